FILE: hdl/cdq_pkg.sv
// ---------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque with indexed access.
// ---------------------------------------------------------------------------
package cdq_pkg;

  localparam int CMD_BITS  = 2;
  localparam int POS_BITS  = 8;
  localparam int DATA_BITS = 32;
  localparam int SIZE_BITS = 7;

  localparam logic signed [POS_BITS-1:0] POS_FRONT = -8'sd1;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_SET    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADIDX = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_LOAD,
    S_MOVE,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] data;
    logic [SIZE_BITS-1:0] size;
    status_t              status;
  } res_t;

endpackage

FILE: hdl/cdq_ram.sv
// ---------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/cdq_ctrl.sv
// ---------------------------------------------------------------------------
// cdq_ctrl
// Command decode, ring pointers and the move sequencer around the word RAM.
// ---------------------------------------------------------------------------
module cdq_ctrl #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cdq_pkg::CMD_BITS-1:0]         cmd,
  input  logic signed [cdq_pkg::POS_BITS-1:0]  pos,
  input  logic [WORD_BITS-1:0]                 word,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output cdq_pkg::res_t                        res,
  output logic                                 ram_we,
  output logic [$clog2(CAPACITY)-1:0]          ram_waddr,
  output logic [WORD_BITS-1:0]                 ram_wdata,
  output logic                                 ram_re,
  output logic [$clog2(CAPACITY)-1:0]          ram_raddr,
  input  logic [WORD_BITS-1:0]                 ram_rdata
);

  import cdq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = POS_BITS - 1;
  localparam int XW = (CW > PW) ? CW : PW;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    return (p == AW'(CAPACITY - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(CAPACITY - 1) : p - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  state_t               state_r, state_nxt;
  logic [AW-1:0]        front_r, front_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        cur_r, cur_nxt;
  logic [AW-1:0]        wdst_r, wdst_nxt;
  logic                 dir_r, dir_nxt;
  logic                 pend_r, pend_nxt;
  logic [CW-1:0]        moves_r, moves_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  status_t              status_r, status_nxt;
  logic [DATA_BITS-1:0] dout_r, dout_nxt;

  // decode
  cmd_t          cmd_in;
  logic          is_front, neg, set_ins, is_ins, full, bad, back_side;
  logic [PW-1:0] p7;
  logic [XW-1:0] p_x, cnt_x;
  logic [CW-1:0] idx;
  logic [CW:0]   idx2;
  logic [AW-1:0] src;

  always_comb begin
    cmd_in    = cmd_t'(cmd);
    is_front  = (pos == POS_FRONT);
    neg       = pos[POS_BITS-1];
    p7        = is_front ? '0 : pos[PW-1:0];
    p_x       = XW'(p7);
    cnt_x     = XW'(count_r);
    idx       = CW'(p_x);
    idx2      = {idx, 1'b0};
    back_side = (idx2 >= {1'b0, count_r});
    full      = (count_r == CW'(CAPACITY));
    set_ins   = (cmd_in == CMD_SET) && (is_front || (!neg && p_x == cnt_x));
    is_ins    = (cmd_in == CMD_INSERT) || set_ins;
    if (is_ins) begin
      bad = !set_ins && ((neg && !is_front) || (p_x > cnt_x));
    end else begin
      bad = (neg && !is_front) || (p_x >= cnt_x);
    end
    src = dir_r ? ring_inc(cur_r) : ring_dec(cur_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    wdst_r   <= wdst_nxt;
    dir_r    <= dir_nxt;
    moves_r  <= moves_nxt;
    word_r   <= word_nxt;
    cmd_r    <= cmd_nxt;
    status_r <= status_nxt;
    dout_r   <= dout_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    count_nxt  = count_r;
    cur_nxt    = cur_r;
    wdst_nxt   = wdst_r;
    dir_nxt    = dir_r;
    pend_nxt   = pend_r;
    moves_nxt  = moves_r;
    word_nxt   = word_r;
    cmd_nxt    = cmd_r;
    status_nxt = status_r;
    dout_nxt   = dout_r;
    ram_we     = 1'b0;
    ram_waddr  = wdst_r;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = cur_r;
    in_stall   = 1'b1;
    res_valid  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          word_nxt   = word;
          dout_nxt   = '0;
          status_nxt = STAT_OK;
          moves_nxt  = '0;
          pend_nxt   = 1'b0;
          cmd_nxt    = is_ins ? CMD_INSERT : cmd_in;
          if (bad) begin
            status_nxt = STAT_BADIDX;
            state_nxt  = S_FIN;
          end else if (is_ins && full) begin
            status_nxt = STAT_FULL;
            state_nxt  = S_FIN;
          end else if (is_ins) begin
            count_nxt = count_r + CW'(1);
            state_nxt = S_MOVE;
            if (back_side) begin
              cur_nxt   = ring_add(front_r, count_r);
              dir_nxt   = 1'b0;
              moves_nxt = count_r - idx;
            end else begin
              cur_nxt   = ring_dec(front_r);
              front_nxt = ring_dec(front_r);
              dir_nxt   = 1'b1;
              moves_nxt = idx;
            end
          end else begin
            cur_nxt   = ring_add(front_r, idx);
            state_nxt = S_RD;
            if (cmd_in == CMD_REMOVE) begin
              count_nxt = count_r - CW'(1);
              if (back_side) begin
                dir_nxt   = 1'b1;
                moves_nxt = count_r - CW'(1) - idx;
              end else begin
                dir_nxt   = 1'b0;
                moves_nxt = idx;
                front_nxt = ring_inc(front_r);
              end
            end
          end
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cur_r;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        dout_nxt = DATA_BITS'(ram_rdata);
        if (cmd_r == CMD_SET) begin
          ram_we    = 1'b1;
          ram_waddr = cur_r;
          ram_wdata = word_r;
        end
        state_nxt = (cmd_r == CMD_REMOVE) ? S_MOVE : S_FIN;
      end
      S_MOVE: begin
        ram_we = pend_r;
        if (moves_r != '0) begin
          ram_re    = 1'b1;
          ram_raddr = src;
          wdst_nxt  = cur_r;
          cur_nxt   = src;
          moves_nxt = moves_r - CW'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (cmd_r == CMD_INSERT) begin
              ram_we    = 1'b1;
              ram_waddr = cur_r;
              ram_wdata = word_r;
            end
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res.data   = dout_r;
  assign res.size   = SIZE_BITS'(count_r);
  assign res.status = status_r;

endmodule

FILE: hdl/circular_deque_indexed_insert_remove_top.sv
// ---------------------------------------------------------------------------
// circular_deque_indexed_insert_remove_top
// Ring-buffer deque with insert, remove, get and set at a logical index.
// ---------------------------------------------------------------------------
// One command is in flight at a time; each gives one result. An insert
// or a remove shifts m words, where m is at most half the stored words;
// the word RAM moves one word per cycle through its single read and
// single write port. The next command is taken as soon as the result sits
// in the output register. The store needs no clearing after reset.
module circular_deque_indexed_insert_remove_top #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cdq_pkg::CMD_BITS-1:0]         in_command,
  input  logic signed [cdq_pkg::POS_BITS-1:0]  in_position,
  input  logic [cdq_pkg::DATA_BITS-1:0]        in_data_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [cdq_pkg::DATA_BITS-1:0]        out_data_out,
  output logic [cdq_pkg::SIZE_BITS-1:0]        out_size_after,
  output logic [1:0]                           out_status
);

  import cdq_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic                 res_valid, res_ready;
  res_t                 res;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_r, out_nxt;

  cdq_ctrl #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (in_command),
    .pos       (in_position),
    .word      (WORD_BITS'(in_data_in)),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  cdq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register: frees the sequencer while a result waits for transfer
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_r.data;
  assign out_size_after = out_r.size;
  assign out_status     = out_r.status;

endmodule

FILE: tb/deque_result_monitor.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// deque_result_monitor
// Watches both channels of the indexed circular deque. Every input transfer
// is applied to a shadow copy of the deque contents, held as a plain queue
// in logical order. The predicted word, size and status go into a list of
// owed results. Each output transfer is checked against the oldest one.
// ---------------------------------------------------------------------------
module deque_result_monitor #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [cdq_pkg::CMD_BITS-1:0]         in_command,
  input  logic signed [cdq_pkg::POS_BITS-1:0]  in_position,
  input  logic [cdq_pkg::DATA_BITS-1:0]        in_data_in,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [cdq_pkg::DATA_BITS-1:0]        out_data_out,
  input  logic [cdq_pkg::SIZE_BITS-1:0]        out_size_after,
  input  logic [1:0]                           out_status,
  output int                                   mismatches,
  output int                                   results_owed,
  output int                                   words_held
);

  import cdq_pkg::*;

  logic [DATA_BITS-1:0] shadow_words[$];
  res_t                 owed_results[$];
  res_t                 oldest;

  task automatic flag_mismatch(string what, logic [DATA_BITS-1:0] got,
                               logic [DATA_BITS-1:0] want);
    $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Applies one command to the shadow deque; -1 aliases the front, and a
  // set at either end behaves as an insert.
  function automatic res_t predict_command(cmd_t cmd, logic signed [POS_BITS-1:0] pos_raw,
                                           logic [DATA_BITS-1:0] word);
    int   n;
    int   idx;
    res_t r;
    n        = shadow_words.size();
    idx      = pos_raw;
    r.data   = '0;
    r.status = STAT_OK;
    if (cmd == CMD_INSERT || (cmd == CMD_SET && (idx == -1 || idx == n))) begin
      if (idx == -1) idx = 0;
      if (idx < 0 || idx > n) begin
        r.status = STAT_BADIDX;
      end else if (n >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        shadow_words.insert(idx, word);
      end
    end else begin
      if (idx == -1) idx = 0;
      if (idx < 0 || idx >= n) begin
        r.status = STAT_BADIDX;
      end else begin
        r.data = shadow_words[idx];
        if (cmd == CMD_REMOVE) begin
          shadow_words.delete(idx);
        end else if (cmd == CMD_SET) begin
          shadow_words[idx] = word;
        end
      end
    end
    r.size = SIZE_BITS'(shadow_words.size());
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_words.delete();
      owed_results.delete();
    end else begin
      // result side first: a result in the same cycle belongs to an earlier command
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          flag_mismatch("unexpected transfer", out_data_out, '0);
        end else begin
          oldest = owed_results.pop_front();
          if (out_data_out !== oldest.data)
            flag_mismatch("data_out", out_data_out, oldest.data);
          if (out_size_after !== oldest.size)
            flag_mismatch("size_after", out_size_after, oldest.size);
          if (out_status !== oldest.status)
            flag_mismatch("status", out_status, oldest.status);
        end
      end
      if (in_valid && !in_stall)
        owed_results.push_back(predict_command(cmd_t'(in_command), in_position, in_data_in));
    end
    results_owed <= owed_results.size();
    words_held   <= shadow_words.size();
  end

endmodule

FILE: tb/circular_deque_indexed_insert_remove_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// circular_deque_indexed_insert_remove_top_tb
// Drives insert, remove, get and set commands into the indexed circular
// deque: a short directed run through the ends, the front alias, set at the
// ends and bad indexes, then phases that fill, drain and churn the store
// with random gaps on both sides and two long receiver hold-offs.
// ---------------------------------------------------------------------------
module circular_deque_indexed_insert_remove_top_tb;
  import cdq_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1100;

  typedef enum int {FILL_UP, DRAIN_DOWN, CHURN} mix_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [CMD_BITS-1:0]         in_command;
  logic signed [POS_BITS-1:0]  in_position;
  logic [DATA_BITS-1:0]        in_data_in;
  logic                        out_valid;
  logic                        out_stall;
  logic [DATA_BITS-1:0]        out_data_out;
  logic [SIZE_BITS-1:0]        out_size_after;
  logic [1:0]                  out_status;

  int mismatches;
  int results_owed;
  int words_held;
  int idle_cycles = 0;
  int results_taken = 0;
  bit quiet_sender = 1'b0;

  always #2 clk = ~clk;

  circular_deque_indexed_insert_remove_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_position   (in_position),
    .in_data_in    (in_data_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data_out  (out_data_out),
    .out_size_after(out_size_after),
    .out_status    (out_status)
  );

  deque_result_monitor monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_position   (in_position),
    .in_data_in    (in_data_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data_out  (out_data_out),
    .out_size_after(out_size_after),
    .out_status    (out_status),
    .mismatches    (mismatches),
    .results_owed  (results_owed),
    .words_held    (words_held)
  );

  task automatic send_command(cmd_t cmd, int pos, logic [DATA_BITS-1:0] word);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_position <= pos[POS_BITS-1:0];
    in_data_in  <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic cmd_t pick_command(mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      FILL_UP: begin
        if (r < 80) return CMD_INSERT;
        if (r < 88) return CMD_SET;
        if (r < 94) return CMD_GET;
        return CMD_REMOVE;
      end
      DRAIN_DOWN: begin
        if (r < 80) return CMD_REMOVE;
        if (r < 88) return CMD_GET;
        if (r < 94) return CMD_SET;
        return CMD_INSERT;
      end
      default: begin
        if (r < 30) return CMD_INSERT;
        if (r < 60) return CMD_REMOVE;
        if (r < 80) return CMD_GET;
        return CMD_SET;
      end
    endcase
  endfunction

  // size seen here lags by one transfer; only the bias suffers
  function automatic int pick_position(int n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return -1;
    if (r < 20) return 0;
    if (r < 35) return n;
    if (r < 45) return n - 1;
    if (r < 90) return $urandom_range(0, n);
    return $urandom_range(0, 255);
  endfunction

  initial begin
    int   phase_len;
    int   sent;
    mix_t mix;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_command  <= CMD_GET;
    in_position <= '0;
    in_data_in  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty store, front alias, set at both ends
    send_command(CMD_GET,    -1, 32'h0000_0000);
    send_command(CMD_REMOVE,  0, 32'h0000_0000);
    send_command(CMD_INSERT,  1, 32'h1234_5678);
    send_command(CMD_SET,    -1, 32'hFFFF_FFFF);
    send_command(CMD_SET,     1, 32'h0000_0000);
    send_command(CMD_INSERT, -1, 32'hA5A5_A5A5);
    send_command(CMD_INSERT,  3, 32'h5A5A_5A5A);
    send_command(CMD_INSERT,  2, 32'hDEAD_BEEF);
    send_command(CMD_INSERT,  1, 32'h0F0F_0F0F);
    send_command(CMD_GET,    -1, 32'h0000_0000);
    send_command(CMD_GET,     2, 32'h0000_0000);
    send_command(CMD_SET,     3, 32'hFFFF_FFFF);
    send_command(CMD_SET,     0, 32'h0000_0000);
    send_command(CMD_REMOVE,  3, 32'h0000_0000);
    send_command(CMD_REMOVE, -1, 32'h0000_0000);
    send_command(CMD_REMOVE,  3, 32'h0000_0000);
    // bad indexes
    send_command(CMD_INSERT, 127, 32'hFFFF_FFFF);
    send_command(CMD_GET,   -128, 32'h0000_0000);
    send_command(CMD_SET,     64, 32'h8000_0001);
    send_command(CMD_REMOVE,   3, 32'h0000_0000);
    send_command(CMD_INSERT,  -2, 32'h7FFF_FFFE);
    send_command(CMD_GET,     85, 32'h0000_0000);
    send_command(CMD_GET,      2, 32'h0000_0000);

    sent = 0;
    mix  = FILL_UP;
    while (sent < RANDOM_ITEMS) begin
      phase_len    = (mix == CHURN) ? $urandom_range(40, 100) : $urandom_range(90, 120);
      quiet_sender = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        send_command(pick_command(mix), pick_position(words_held), $urandom());
        sent++;
      end
      mix = mix_t'($urandom_range(0, 2));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("circular_deque_indexed_insert_remove_top_tb passed");
    end else begin
      $display("circular_deque_indexed_insert_remove_top_tb failed");
    end
    $finish;
  end

  // receiver: random stalls, stall-free stretches, two long hold-offs
  initial begin
    int hold;
    out_stall <= 1'b0;
    forever begin
      if (results_taken == 150 || results_taken == 650) begin
        hold = HOLD_CYCLES;
      end else if ((results_taken / 64) % 4 == 1) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 12);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("circular_deque_indexed_insert_remove_top_tb failed");
        $finish;
      end
    end
  end

endmodule
